/* hdl/smb_pkg.sv */
// Shared types and constants for the SPI mode-0 master byte shifter.
`default_nettype none

package smb_pkg;

	localparam int WORD_BITS_DEFAULT = 8;

	localparam logic [2:0] ACT_TICK       = 3'd0;
	localparam logic [2:0] ACT_SELECT     = 3'd1;
	localparam logic [2:0] ACT_RELEASE    = 3'd2;
	localparam logic [2:0] ACT_WRITE      = 3'd3;
	localparam logic [2:0] ACT_WRITE_READ = 3'd4;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] data_byte;
		logic       miso_level;
	} req_item_t;

	typedef struct packed {
		logic       sck_level;
		logic       mosi_level;
		logic       select_n_level;
		logic [7:0] read_byte;
		logic       done_res;
		logic       busy_res;
		logic       rejected;
	} rsp_item_t;

endpackage

`default_nettype wire

/* hdl/smb_core.sv */
// Shift state and per-tick next-state logic of the SPI mode-0 master.
`default_nettype none

module smb_core #(
	parameter int WORD_BITS = smb_pkg::WORD_BITS_DEFAULT
) (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic step_en,
	input  wire smb_pkg::req_item_t item,
	output smb_pkg::rsp_item_t result
);

	localparam int CNT_W = $clog2(WORD_BITS + 2);

	logic [WORD_BITS-1:0] out_shift_q, out_shift_n;
	logic [WORD_BITS-1:0] in_shift_q, in_shift_n;
	logic [CNT_W-1:0]     clocks_left_q, clocks_left_n;
	logic                 high_half_q, high_half_n;
	logic                 read_mode_q, read_mode_n;
	logic                 active_q, active_n;
	logic                 select_n_q, select_n_n;

	logic                 is_cmd;
	logic                 read_cmd;
	logic [WORD_BITS+7:0] data_ext;
	logic [WORD_BITS+7:0] in_ext;

	assign data_ext = {WORD_BITS'(0), item.data_byte};
	assign in_ext   = {8'd0, in_shift_q};
	assign read_cmd = (item.action == smb_pkg::ACT_WRITE_READ);

	always_comb begin
		is_cmd        = item.action inside {[smb_pkg::ACT_SELECT:smb_pkg::ACT_WRITE_READ]};
		out_shift_n   = out_shift_q;
		in_shift_n    = in_shift_q;
		clocks_left_n = clocks_left_q;
		high_half_n   = high_half_q;
		read_mode_n   = read_mode_q;
		active_n      = active_q;
		select_n_n    = select_n_q;
		result        = '0;
		if (active_q) begin
			result.rejected = is_cmd;
			if (high_half_q) begin
				result.sck_level  = 1'b1;
				result.mosi_level = out_shift_q[WORD_BITS-1];
				if (read_mode_q) begin
					in_shift_n = {in_shift_q[WORD_BITS-2:0], item.miso_level};
				end
				out_shift_n = {out_shift_q[WORD_BITS-2:0], 1'b0};
				if (clocks_left_q != '0) begin
					clocks_left_n = clocks_left_q - CNT_W'(1);
				end
				high_half_n = 1'b0;
			end else if (clocks_left_q != '0) begin
				result.mosi_level = out_shift_q[WORD_BITS-1];
				high_half_n       = 1'b1;
			end else begin
				result.done_res = 1'b1;
				if (read_mode_q) begin
					result.read_byte = in_ext[7:0];
				end
				active_n    = 1'b0;
				read_mode_n = 1'b0;
			end
		end else begin
			case (item.action)
				smb_pkg::ACT_SELECT: begin
					select_n_n = 1'b0;
				end
				smb_pkg::ACT_RELEASE: begin
					select_n_n = 1'b1;
				end
				smb_pkg::ACT_WRITE, smb_pkg::ACT_WRITE_READ: begin
					out_shift_n       = data_ext[WORD_BITS-1:0];
					in_shift_n        = '0;
					read_mode_n       = read_cmd;
					clocks_left_n     = CNT_W'(WORD_BITS) + CNT_W'(read_cmd);
					active_n          = 1'b1;
					high_half_n       = 1'b1;
					result.mosi_level = data_ext[WORD_BITS-1];
				end
				default: begin
				end
			endcase
		end
		result.select_n_level = select_n_n;
		result.busy_res       = active_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_shift_q   <= '0;
			in_shift_q    <= '0;
			clocks_left_q <= '0;
			high_half_q   <= 1'b0;
			read_mode_q   <= 1'b0;
			active_q      <= 1'b0;
			select_n_q    <= 1'b1;
		end else if (step_en) begin
			out_shift_q   <= out_shift_n;
			in_shift_q    <= in_shift_n;
			clocks_left_q <= clocks_left_n;
			high_half_q   <= high_half_n;
			read_mode_q   <= read_mode_n;
			active_q      <= active_n;
			select_n_q    <= select_n_n;
		end
	end

endmodule

`default_nettype wire

/* hdl/spi_mode0_master_byte_shifter.sv */
// Top level of the tick-driven SPI mode-0 master byte shifter.
//
// Each transfer on the req channel is one half-bit tick of the serial clock. It carries
// a command (tick only, assert select, release select, write, write-read), the byte to
// send and the sampled MISO level. Each tick produces exactly one transfer on the rsp
// channel with the pin levels to drive, the received byte, and done, busy and reject
// flags. Commands that arrive while a byte transfer runs are ignored and flagged.
// A tick passes an input register and then the shift logic into a result register.
// One tick is accepted per cycle as long as the receiver keeps up, since the shift
// state updates with every accepted tick.
// A write takes 2*WORD_BITS+1 ticks and a write-read 2*WORD_BITS+3 ticks.
// When the receiver stalls, the result and input registers hold and req_ready drops
// once both are full. Reset empties both registers, deselects the chip and clears
// the shift state.
`default_nettype none

module spi_mode0_master_byte_shifter #(
	parameter int WORD_BITS = smb_pkg::WORD_BITS_DEFAULT
) (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic req_valid,
	output logic               req_ready,
	input  wire smb_pkg::req_item_t req,
	output logic               rsp_valid,
	input  wire                logic rsp_ready,
	output smb_pkg::rsp_item_t rsp
);

	smb_pkg::req_item_t item_s1;
	logic               valid_s1;
	smb_pkg::rsp_item_t result;
	smb_pkg::rsp_item_t rsp_q;
	logic               rsp_valid_q;
	logic               advance;
	logic               step_en;

	assign advance   = !rsp_valid_q || rsp_ready;
	assign step_en   = valid_s1 && advance;
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req;
		end
	end

	smb_core #(
		.WORD_BITS(WORD_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(step_en),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			rsp_q <= result;
		end
	end

endmodule

`default_nettype wire

/* tb/smb_pin_checker.sv */
// Predicts the pin levels and flags of each tick and compares them with the block's results.
module smb_pin_checker #(
	parameter int WORD_BITS = smb_pkg::WORD_BITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  smb_pkg::req_item_t req,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  smb_pkg::rsp_item_t rsp,
	output int                 fail_count,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [WORD_BITS-1:0] out_shift = '0;
	logic [WORD_BITS-1:0] in_shift = '0;
	int                   clocks_left = 0;
	logic                 high_half = 1'b0;
	logic                 read_mode = 1'b0;
	logic                 active = 1'b0;
	logic                 select_n = 1'b1;

	smb_pkg::rsp_item_t pins_due[$];
	int                 mismatches = 0;
	int                 pending_now = 0;
	int                 results_seen = 0;

	assign fail_count = mismatches;
	assign outstanding = pending_now;

	function automatic smb_pkg::rsp_item_t next_pins(smb_pkg::req_item_t t);
		smb_pkg::rsp_item_t r;
		logic               is_cmd;
		r = '0;
		is_cmd = (t.action >= smb_pkg::ACT_SELECT) && (t.action <= smb_pkg::ACT_WRITE_READ);
		if (active) begin
			r.rejected = is_cmd;
			if (high_half) begin
				r.sck_level = 1'b1;
				r.mosi_level = out_shift[WORD_BITS-1];
				if (read_mode)
					in_shift = {in_shift[WORD_BITS-2:0], t.miso_level};
				out_shift = out_shift << 1;
				if (clocks_left > 0)
					clocks_left--;
				high_half = 1'b0;
			end else if (clocks_left > 0) begin
				r.mosi_level = out_shift[WORD_BITS-1];
				high_half = 1'b1;
			end else begin
				r.done_res = 1'b1;
				if (read_mode)
					r.read_byte = 8'(in_shift);
				active = 1'b0;
				read_mode = 1'b0;
			end
		end else begin
			case (t.action)
				smb_pkg::ACT_SELECT: select_n = 1'b0;
				smb_pkg::ACT_RELEASE: select_n = 1'b1;
				smb_pkg::ACT_WRITE, smb_pkg::ACT_WRITE_READ: begin
					out_shift = WORD_BITS'(t.data_byte);
					in_shift = '0;
					read_mode = (t.action == smb_pkg::ACT_WRITE_READ);
					clocks_left = WORD_BITS + int'(read_mode);
					active = 1'b1;
					r.mosi_level = out_shift[WORD_BITS-1];
					high_half = 1'b1;
				end
				default: ;
			endcase
		end
		r.select_n_level = select_n;
		r.busy_res = active;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		smb_pkg::rsp_item_t exp_pins;
		if (!arst_n) begin
			out_shift = '0;
			in_shift = '0;
			clocks_left = 0;
			high_half = 1'b0;
			read_mode = 1'b0;
			active = 1'b0;
			select_n = 1'b1;
			pins_due.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				results_seen++;
				if (pins_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result %0d arrived with no tick outstanding: %p",
							results_seen, rsp);
				end else begin
					exp_pins = pins_due.pop_front();
					if (rsp.sck_level !== exp_pins.sck_level
							|| rsp.mosi_level !== exp_pins.mosi_level
							|| rsp.select_n_level !== exp_pins.select_n_level
							|| rsp.read_byte !== exp_pins.read_byte
							|| rsp.done_res !== exp_pins.done_res
							|| rsp.busy_res !== exp_pins.busy_res
							|| rsp.rejected !== exp_pins.rejected) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Result %0d mismatch: expected %p, got %p",
								results_seen, exp_pins, rsp);
					end
				end
			end
			if (req_valid && req_ready)
				pins_due.push_back(next_pins(req));
		end
		pending_now = pins_due.size();
	end
endmodule

/* tb/spi_mode0_master_byte_shifter_tb.sv */
// Stimulus and verdict for the SPI mode-0 master byte shifter.
module spi_mode0_master_byte_shifter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
	localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         PHASE_TICKS = 220;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	smb_pkg::req_item_t req;
	logic               rsp_valid;
	logic               rsp_ready;
	smb_pkg::rsp_item_t rsp;
	int                 fail_count;
	int                 outstanding;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_left = 0;
	int ticks_sent = 0;
	int cycles = 0;

	spi_mode0_master_byte_shifter dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	smb_pin_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// The long hold-off is counted down here while the sender keeps offering ticks.
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	task automatic offer_tick(input logic [2:0] act, input logic [7:0] value, input logic miso);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{action: act, data_byte: value, miso_level: miso};
		do
			@(posedge clk);
		while (!req_ready);
		ticks_sent++;
	endtask

	task automatic pause_until_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic offer_transfer();
		logic       with_read;
		logic [7:0] value;
		logic [2:0] act;
		int         ticks;
		with_read = 1'($urandom_range(1));
		if ($urandom_range(3) != 0)
			offer_tick(smb_pkg::ACT_SELECT, 8'($urandom), 1'($urandom_range(1)));
		case ($urandom_range(7))
			0: value = 8'h00;
			1: value = 8'hFF;
			default: value = 8'($urandom_range(255));
		endcase
		offer_tick(with_read ? smb_pkg::ACT_WRITE_READ : smb_pkg::ACT_WRITE, value,
			1'($urandom_range(1)));
		ticks = with_read ? 18 : 16;
		if ($urandom_range(9) == 0)
			ticks = $urandom_range(ticks + 4);
		for (int i = 0; i < ticks; i++) begin
			act = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : smb_pkg::ACT_TICK;
			offer_tick(act, 8'($urandom), 1'($urandom_range(1)));
		end
		if ($urandom_range(2) != 0)
			offer_tick(smb_pkg::ACT_RELEASE, 8'($urandom), 1'($urandom_range(1)));
	endtask

	initial begin
		logic [2:0] act;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_tick(smb_pkg::ACT_TICK, 8'h00, 1'b0);
		offer_tick(ACT_UNUSED_LO, 8'hFF, 1'b1);
		offer_tick(ACT_UNUSED_HI, 8'h5A, 1'b0);
		offer_tick(smb_pkg::ACT_SELECT, 8'h00, 1'b0);
		offer_tick(smb_pkg::ACT_WRITE_READ, 8'h81, 1'b1);
		for (int i = 1; i <= 18; i++) begin
			act = (i == 6) ? smb_pkg::ACT_WRITE
				: (i == 18) ? smb_pkg::ACT_SELECT : smb_pkg::ACT_TICK;
			offer_tick(act, 8'hC3, 1'(i));
		end
		offer_tick(smb_pkg::ACT_RELEASE, 8'h00, 1'b0);
		pause_until_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
				1: begin tx_idle_pct = 80; rx_stall_pct = 0; end
				2: begin tx_idle_pct = 0; rx_stall_pct = 80; end
				default: begin tx_idle_pct = 6; rx_stall_pct = 6; end
			endcase
			if (ph == 0) begin
				hold_left = 400;
				repeat (40)
					offer_tick(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)));
			end
			while (ticks_sent < 24 + (ph + 1) * PHASE_TICKS) begin
				if ($urandom_range(99) < 15)
					offer_tick(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)));
				else
					offer_transfer();
			end
			pause_until_drained();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
